[sv/pti_pkg.sv]
// pti_pkg: shared types, constants and the pt100 resistance rom
// used by every other file in the project; depends on nothing
package pti_pkg;

    localparam int TableEntries = 105;
    localparam int RomSize      = 105;
    localparam int EntriesInUse = (TableEntries < 2) ? 2 :
                                  ((TableEntries > RomSize) ? RomSize : TableEntries);
    localparam int IdxW         = (EntriesInUse > 2) ? $clog2(EntriesInUse) : 1;
    localparam int LowestDegree = -42;
    localparam int ResW         = 16;
    localparam int TempW        = 15;
    localparam int FracW        = 9;
    localparam int DivSteps     = 9;
    localparam int CntW         = $clog2(DivSteps);

    localparam logic [ResW-1:0] RomData [RomSize] = '{
        16'd8348,  16'd8388,
        16'd8427,  16'd8467,  16'd8506,  16'd8546,  16'd8585,
        16'd8625,  16'd8664,  16'd8704,  16'd8743,  16'd8783,
        16'd8822,  16'd8862,  16'd8901,  16'd8940,  16'd8980,
        16'd9019,  16'd9059,  16'd9098,  16'd9137,  16'd9177,
        16'd9216,  16'd9255,  16'd9295,  16'd9334,  16'd9373,
        16'd9412,  16'd9452,  16'd9491,  16'd9530,  16'd9569,
        16'd9609,  16'd9648,  16'd9687,  16'd9726,  16'd9765,
        16'd9804,  16'd9844,  16'd9883,  16'd9922,  16'd9961,
        16'd10000, 16'd10039, 16'd10078, 16'd10117, 16'd10156,
        16'd10195, 16'd10234, 16'd10273, 16'd10312, 16'd10351,
        16'd10390, 16'd10429, 16'd10468, 16'd10507, 16'd10546,
        16'd10585, 16'd10624, 16'd10663, 16'd10702, 16'd10740,
        16'd10779, 16'd10818, 16'd10857, 16'd10896, 16'd10935,
        16'd10973, 16'd11012, 16'd11051, 16'd11090, 16'd11129,
        16'd11167, 16'd11206, 16'd11245, 16'd11283, 16'd11322,
        16'd11361, 16'd11400, 16'd11438, 16'd11477, 16'd11515,
        16'd11554, 16'd11593, 16'd11631, 16'd11670, 16'd11708,
        16'd11747, 16'd11786, 16'd11824, 16'd11863, 16'd11901,
        16'd11940, 16'd11978, 16'd12017, 16'd12055, 16'd12094,
        16'd12132, 16'd12171, 16'd12209, 16'd12247, 16'd12286,
        16'd12324, 16'd12363, 16'd12401
    };

    localparam logic [ResW-1:0] RomFirst = RomData[0];
    localparam logic [ResW-1:0] RomLast  = RomData[EntriesInUse-1];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_FETCH,
        ST_DIVIDE,
        ST_WRITE
    } pti_state_t;

    typedef struct packed {
        logic load;
        logic mark_oor;
        logic search_step;
        logic fetch;
        logic div_step;
        logic write;
    } pti_cmd_t;

    typedef struct packed {
        logic range_bad;
        logic search_done;
        logic div_last;
        logic out_full;
    } pti_status_t;

    function automatic logic [ResW-1:0] rom_value(input logic [IdxW-1:0] idx);
        logic [ResW-1:0] v;
        v = '0;
        if (int'(idx) < RomSize)
        begin
            v = RomData[idx];
        end
        return v;
    endfunction

endpackage

[sv/pti_ctrl.sv]
// pti_ctrl: sequencer for range check, segment search, divide and result write
// depends on pti_pkg
module pti_ctrl
    import pti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        out_ready,
    input  pti_status_t status,
    output pti_cmd_t    cmd
);

    pti_state_t state_reg;
    pti_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.range_bad)
                begin
                    cmd.mark_oor = 1'b1;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/pti_dp.sv]
// pti_dp: search bounds, restoring divider, temperature assembly, output register
// depends on pti_pkg
module pti_dp
    import pti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ResW-1:0]         resistance_centiohm,
    input  logic                    out_ready,
    input  pti_cmd_t                cmd,
    output pti_status_t             status,
    output logic                    out_valid,
    output logic signed [TempW-1:0] temperature_q8,
    output logic                    out_of_range
);

    logic [ResW-1:0]         r_reg;
    logic [IdxW-1:0]         lo_reg;
    logic [IdxW-1:0]         hi_reg;
    logic [IdxW-1:0]         seg_reg;
    logic [ResW-1:0]         span_reg;
    logic [ResW-1:0]         rem_reg;
    logic [FracW-1:0]        q_reg;
    logic [CntW-1:0]         cnt_reg;
    logic                    oor_reg;
    logic                    out_valid_reg;
    logic signed [TempW-1:0] temp_reg;
    logic                    out_oor_reg;

    logic [IdxW:0]           mid_sum;
    logic [IdxW-1:0]         mid;
    logic [IdxW-1:0]         seg_next;
    logic [ResW-1:0]         lo_val;
    logic [ResW-1:0]         hi_val;
    logic [ResW:0]           trial;
    logic                    ge;
    logic [ResW:0]           diff;
    logic                    span_zero;
    logic [FracW-1:0]        frac;
    logic                    inexact;
    logic signed [15:0]      base_deg;
    logic signed [15:0]      base_q8;
    logic signed [15:0]      val_raw;
    logic signed [15:0]      val_adj;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IdxW:1];
    assign seg_next = lo_reg - IdxW'(1);
    assign lo_val   = rom_value(seg_next);
    assign hi_val   = rom_value(lo_reg);

    assign trial = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign ge    = trial >= {1'b0, span_reg};
    assign diff  = trial - {1'b0, span_reg};

    assign span_zero = (span_reg == '0);
    assign frac      = span_zero ? '0 : q_reg;
    assign inexact   = !span_zero && (rem_reg != '0);
    assign base_deg  = 16'(seg_reg) + 16'(LowestDegree);
    assign base_q8   = base_deg <<< 8;
    assign val_raw   = base_q8 + 16'(frac);
    assign val_adj   = (base_q8 < 0 && inexact && val_raw < 0) ? val_raw + 16'sd1 : val_raw;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg   <= resistance_centiohm;
            lo_reg  <= IdxW'(1);
            hi_reg  <= IdxW'(EntriesInUse - 1);
            oor_reg <= 1'b0;
        end
        if (cmd.mark_oor)
        begin
            oor_reg <= 1'b1;
        end
        if (cmd.search_step)
        begin
            if (r_reg <= rom_value(mid))
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + IdxW'(1);
            end
        end
        if (cmd.fetch)
        begin
            seg_reg  <= seg_next;
            span_reg <= hi_val - lo_val;
            rem_reg  <= r_reg - lo_val;
            q_reg    <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[ResW-1:0] : trial[ResW-1:0];
            q_reg   <= {q_reg[FracW-2:0], ge};
            cnt_reg <= cnt_reg + CntW'(1);
        end
        if (cmd.write)
        begin
            out_oor_reg <= oor_reg;
            temp_reg    <= oor_reg ? '0 : val_adj[TempW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.range_bad   = (r_reg < RomFirst) || (r_reg > RomLast);
    assign status.search_done = (lo_reg == hi_reg);
    assign status.div_last    = (cnt_reg == CntW'(DivSteps - 1));
    assign status.out_full    = out_valid_reg;

    assign out_valid      = out_valid_reg;
    assign temperature_q8 = temp_reg;
    assign out_of_range   = out_oor_reg;

endmodule

[sv/pt100_table_interpolator_top.sv]
// pt100_table_interpolator_top: pt100 resistance to q8 temperature converter
// depends on pti_pkg, pti_ctrl, pti_dp
//
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   resistance_centiohm[15:0]
// output    out        out_valid / out_ready temperature_q8[14:0], out_of_range
//
// one word at a time: accept, range check, binary search, fetch, divide and write,
// in that order; an out of range word goes from the range check straight to write
// the search length is set by the rom depth, the divide by the 9 quotient bits
// a finished word waits in the output register; the next word is taken meanwhile
// and stalls only in the write cycle while that register is still full
// reset clears the sequencer and the output valid; no clearing pass
module pt100_table_interpolator_top
    import pti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ResW-1:0]         resistance_centiohm,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [TempW-1:0] temperature_q8,
    output logic                    out_of_range
);

    pti_cmd_t    cmd;
    pti_status_t status;

    pti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pti_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .resistance_centiohm (resistance_centiohm),
        .out_ready           (out_ready),
        .cmd                 (cmd),
        .status              (status),
        .out_valid           (out_valid),
        .temperature_q8      (temperature_q8),
        .out_of_range        (out_of_range)
    );

endmodule

[sv/pti_checker.sv]
// pti_checker: port level assertions for pt100_table_interpolator_top, with bind
// depends on pti_pkg
module pti_checker
    import pti_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [ResW-1:0]         resistance_centiohm,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [TempW-1:0] temperature_q8,
    input logic                    out_of_range
);

    // held result word keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(temperature_q8) && $stable(out_of_range))
    else $error("output word changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> temperature_q8 == '0)
    else $error("out of range word with nonzero temperature");

    a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_of_range |->
            (temperature_q8 >= -15'sd10752) && (temperature_q8 <= 15'sd15872))
    else $error("temperature outside table span");

    // one word at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

endmodule

bind pt100_table_interpolator_top pti_checker u_pti_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .resistance_centiohm (resistance_centiohm),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .temperature_q8      (temperature_q8),
    .out_of_range        (out_of_range)
);

[tb/pt100_table_interpolator_top_tb.sv]
// pt100_table_interpolator_top_tb: checks resistance-to-temperature words against an
// in-bench interpolation predictor, a directed table and random phases of idling
// depends on pti_pkg and pt100_table_interpolator_top
module pt100_table_interpolator_top_tb;
    import pti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod     = 8;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 64;
    localparam int WordsPerPhase = 125;
    localparam int WatchdogNs    = 5_000_000;
    localparam int NumDirected   = 18;

    typedef struct packed {
        logic signed [TempW-1:0] temp;
        logic                    oor;
    } reading_t;

    typedef struct packed {
        logic [ResW-1:0] res;
        logic            golden;
        reading_t        want;
    } stim_row_t;

    localparam reading_t NoReading = '{15'sd0, 1'b1};

    localparam stim_row_t DirectedRows [NumDirected] = '{
        '{16'd0,     1'b1, '{15'sd0, 1'b1}},
        '{16'd65535, 1'b1, '{15'sd0, 1'b1}},
        '{16'd8347,  1'b1, '{15'sd0, 1'b1}},
        '{16'd12402, 1'b1, '{15'sd0, 1'b1}},
        '{16'd8348,  1'b1, '{-15'sd10752, 1'b0}},
        '{16'd12401, 1'b1, '{15'sd15872, 1'b0}},
        '{16'd10000, 1'b1, '{15'sd0, 1'b0}},
        '{16'd8388,  1'b1, '{-15'sd10496, 1'b0}},
        '{16'd21845, 1'b1, '{15'sd0, 1'b1}},
        '{16'd43690, 1'b1, '{15'sd0, 1'b1}},
        '{16'd32768, 1'b1, '{15'sd0, 1'b1}},
        '{16'd8349,  1'b0, NoReading},
        '{16'd8387,  1'b0, NoReading},
        '{16'd9999,  1'b0, NoReading},
        '{16'd10001, 1'b0, NoReading},
        '{16'd12400, 1'b0, NoReading},
        '{16'd10740, 1'b0, NoReading},
        '{16'd11111, 1'b0, NoReading}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [ResW-1:0]         resistance_centiohm = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [TempW-1:0] temperature_q8;
    logic                    out_of_range;

    reading_t expected_readings [$];
    int       mismatch_count = 0;
    int       in_idle_pct = 0;
    int       out_stall_pct = 0;
    int       hold_off_seq = 0;
    int       hold_off_seen = 0;
    int       hold_off_left = 0;

    pt100_table_interpolator_top uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .resistance_centiohm (resistance_centiohm),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .temperature_q8      (temperature_q8),
        .out_of_range        (out_of_range)
    );

    always #(ClkPeriod/2) clk = ~clk;

    function automatic reading_t predict_reading(input logic [ResW-1:0] r);
        reading_t    rd;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned num;
        int unsigned frac;
        bit          inexact;
        bit          found;
        int          base;
        int          val;
        rd = NoReading;
        found = 1'b0;
        if (r >= RomData[0] && r <= RomData[EntriesInUse-1])
        begin
            for (int i = 0; i + 1 < EntriesInUse; i++)
            begin
                lo = RomData[i];
                hi = RomData[i+1];
                if (!found && r >= lo && r <= hi)
                begin
                    found = 1'b1;
                    span = hi - lo;
                    frac = 0;
                    inexact = 1'b0;
                    if (span != 0)
                    begin
                        num = (r - lo) << 8;
                        frac = num / span;
                        inexact = (num % span) != 0;
                    end
                    base = (i + LowestDegree) * 256;
                    val = base + int'(frac);
                    if (base < 0 && inexact && val < 0)
                    begin
                        val = val + 1;
                    end
                    rd.temp = val[TempW-1:0];
                    rd.oor = 1'b0;
                end
            end
        end
        return rd;
    endfunction

    task automatic send_word(input logic [ResW-1:0] r, input reading_t want);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        resistance_centiohm <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_readings.push_back(want);
    endtask

    // receiver side: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_seen != hold_off_seq)
        begin
            hold_off_seen <= hold_off_seq;
            hold_off_left <= HoldOffCycles;
            out_ready <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected word temperature %0d out_of_range %0b",
                         $time, $signed(temperature_q8), out_of_range);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                if (out_of_range !== expected_readings[0].oor ||
                    (!expected_readings[0].oor &&
                     temperature_q8 !== expected_readings[0].temp))
                begin
                    $display("%0t: mismatch expected temp %0d oor %0b actual temp %0d oor %0b",
                             $time, $signed(expected_readings[0].temp),
                             expected_readings[0].oor, $signed(temperature_q8), out_of_range);
                    mismatch_count <= mismatch_count + 1;
                end
                void'(expected_readings.pop_front());
            end
        end
    end

    initial
    begin
        #(WatchdogNs);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [ResW-1:0] r;
        int              kind;
        int              idx;
        int              v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int d = 0; d < NumDirected; d++)
        begin
            send_word(DirectedRows[d].res,
                      DirectedRows[d].golden ? DirectedRows[d].want
                                             : predict_reading(DirectedRows[d].res));
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                    hold_off_seq = hold_off_seq + 1;
                end
                1:
                begin
                    in_idle_pct = 72;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 72;
                end
                default:
                begin
                    in_idle_pct = 36;
                    out_stall_pct = 36;
                end
            endcase
            for (int k = 0; k < WordsPerPhase; k++)
            begin
                kind = $urandom_range(99);
                if (kind < 60)
                begin
                    r = ResW'($urandom_range(int'(RomData[EntriesInUse-1]),
                                             int'(RomData[0])));
                end
                else if (kind < 70)
                begin
                    idx = $urandom_range(EntriesInUse-1);
                    r = RomData[idx];
                end
                else if (kind < 80)
                begin
                    idx = $urandom_range(EntriesInUse-1);
                    v = int'(RomData[idx]) + int'($urandom_range(4)) - 2;
                    r = v[ResW-1:0];
                end
                else if (kind < 88)
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        v = int'(RomData[0]) + int'($urandom_range(16)) - 8;
                    end
                    else
                    begin
                        v = int'(RomData[EntriesInUse-1]) + int'($urandom_range(16)) - 8;
                    end
                    r = v[ResW-1:0];
                end
                else
                begin
                    r = ResW'($urandom_range(65535));
                end
                send_word(r, predict_reading(r));
            end
        end

        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
